[hdl/indexed_dary_min_heap_macros.svh]
// Assertion macros shared by the heap RTL.
// No dependencies; included by the files that carry checks.
`ifndef INDEXED_DARY_MIN_HEAP_MACROS_SVH
`define INDEXED_DARY_MIN_HEAP_MACROS_SVH
`ifndef ASSERT_OFF
`define IDMH_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("idmh check failed");
`define IDMH_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("idmh check failed");
`else
`define IDMH_ASSERT(lbl, clk, rst, prop)
`define IDMH_NEVER(lbl, clk, rst, cond)
`endif
`endif

[hdl/idmh_pkg.sv]
// Shared types, constants and the reciprocal table of the d-ary heap.
// No dependencies.
package idmh_pkg;
  localparam int CAPACITY    = 256;
  localparam int ID_COUNT    = 256;
  localparam int PRIO_BITS   = 16;
  localparam int MAX_ARITY   = 8;
  localparam int SLOT_W      = 8;
  localparam int ID_W        = 8;
  localparam int CNT_W       = 9;
  localparam int ARITY_W     = 4;
  localparam int CHILD_W     = 12;
  localparam int RECIP_W     = 12;
  localparam int QPROD_W     = SLOT_W + RECIP_W;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_EXTRACT  = 2'd1;
  localparam logic [1:0] ACT_DECREASE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_LARGER   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DUP      = 3'd5;

  localparam logic [0:0] REG_ARITY = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  // floor(4096 / d)
  function automatic logic [RECIP_W-1:0] recip(input logic [ARITY_W-1:0] d);
    logic [RECIP_W-1:0] r;
    begin
      case (d)
        4'd3:    r = 12'd1365;
        4'd4:    r = 12'd1024;
        4'd5:    r = 12'd819;
        4'd6:    r = 12'd682;
        4'd7:    r = 12'd585;
        4'd8:    r = 12'd512;
        default: r = 12'd2048;
      endcase
      return r;
    end
  endfunction
endpackage

[hdl/idmh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idmh_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/indexed_dary_min_heap.sv]
// Indexed d-ary min-heap top level: sequencer, shared compare unit, register port.
// Depends on idmh_pkg, idmh_ram and indexed_dary_min_heap_macros.svh.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    action, task_id, priority_req
//  out      source     out_valid/out_stall  status, removed_id, entry_count
//  cfg      APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// Errors go straight to S_FIN. Insert climbs a level per S_UP_CHK, S_UP_DIV, S_UP_CMP;
// decrease first reads the map and entry in S_DK_MAP and S_DK_ENT, and may reject there.
// Extract reads the root, then the last entry if any remain, then per level S_DN_START,
// S_DN_SCAN reading children one a cycle from the single read port (at most d), S_DN_DEC.
// Reset clears count, present bits and sets arity to 2; no clearing pass.
// in_stall is high until the result is loaded; a stalled output holds it in FIN.
`include "indexed_dary_min_heap_macros.svh"
module indexed_dary_min_heap (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic [idmh_pkg::ID_W-1:0]         task_id,
  input  logic [idmh_pkg::PRIO_BITS-1:0]    priority_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic [idmh_pkg::ID_W-1:0]         removed_id,
  output logic [idmh_pkg::CNT_W-1:0]        entry_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import idmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EX_ROOT, S_EX_LAST, S_DK_MAP, S_DK_ENT, S_UP_CHK, S_UP_DIV,
    S_UP_CMP, S_DN_START, S_DN_SCAN, S_DN_DEC, S_FIN
  } state_t;

  state_t               state;
  logic [ARITY_W-1:0]   arity;
  logic [ARITY_W-1:0]   d;
  logic [CNT_W-1:0]     occ;
  logic [ID_COUNT-1:0]  present;
  entry_t               cur;
  entry_t               best;
  logic                 best_vld;
  logic [SLOT_W-1:0]    best_slot;
  logic [SLOT_W-1:0]    hole;
  logic [SLOT_W-1:0]    q0;
  logic [SLOT_W-1:0]    par;
  logic [CHILD_W-1:0]   cidx;
  logic [ARITY_W-1:0]   kcnt;
  logic [2:0]           res_status;
  logic [ID_W-1:0]      res_min;

  logic                 heap_we;
  logic [SLOT_W-1:0]    heap_waddr;
  entry_t               heap_wdata;
  logic [SLOT_W-1:0]    heap_raddr;
  entry_t               heap_rdata;
  logic                 map_we;
  logic [ID_W-1:0]      map_waddr;
  logic [SLOT_W-1:0]    map_wdata;
  logic [ID_W-1:0]      map_raddr;
  logic [SLOT_W-1:0]    map_rdata;

  logic [SLOT_W-1:0]    hole_m1;
  logic [QPROD_W-1:0]   qprod;
  logic [CHILD_W-1:0]   qd;
  logic [CHILD_W-1:0]   rem;
  logic [SLOT_W-1:0]    par_c;
  logic [CHILD_W-1:0]   child_base;
  logic [CHILD_W-1:0]   cidx_inc;
  logic                 scan_more;
  logic [CNT_W-1:0]     last;
  logic [PRIO_BITS-1:0] cmp_a;
  logic [PRIO_BITS-1:0] cmp_b;
  logic                 lt;
  logic                 accept;
  logic                 cfg_wr;
  logic [2:0]           acc_status;
  state_t               acc_state;

  idmh_ram #(.DEPTH(CAPACITY), .WIDTH($bits(entry_t))) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  idmh_ram #(.DEPTH(ID_COUNT), .WIDTH(SLOT_W)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign prdata   = {28'd0, arity};
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_ARITY);

  always_comb begin
    if (arity < 4'd2) begin
      d = 4'd2;
    end else if (arity > 4'(MAX_ARITY)) begin
      d = 4'(MAX_ARITY);
    end else begin
      d = arity;
    end
  end

  // first decision on an accepted transaction
  always_comb begin
    acc_status = ST_OK;
    acc_state  = S_FIN;
    unique case (action)
      ACT_INSERT: begin
        if (occ == 9'(CAPACITY)) begin
          acc_status = ST_FULL;
        end else if (present[task_id]) begin
          acc_status = ST_DUP;
        end else begin
          acc_state = S_UP_CHK;
        end
      end
      ACT_EXTRACT: begin
        if (occ == '0) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_state = S_EX_ROOT;
        end
      end
      ACT_DECREASE: begin
        if (!present[task_id]) begin
          acc_status = ST_NOTFOUND;
        end else begin
          acc_state = S_DK_MAP;
        end
      end
      default: ;
    endcase
  end

  // parent index by reciprocal multiply, corrected in S_UP_DIV
  assign hole_m1    = hole - 8'd1;
  assign qprod      = {12'd0, hole_m1} * {8'd0, recip(d)};
  assign qd         = {4'd0, q0} * {8'd0, d};
  assign rem        = {4'd0, hole_m1} - qd;
  assign par_c      = (rem >= {8'd0, d}) ? q0 + 8'd1 : q0;
  assign child_base = ({8'd0, d} * {4'd0, hole}) + 12'd1;
  assign cidx_inc   = cidx + 12'd1;
  assign scan_more  = ((kcnt + 4'd1) < d) && (cidx_inc < {3'd0, occ});
  assign last       = occ - 9'd1;

  // shared compare unit
  always_comb begin
    unique case (state)
      S_DK_ENT:  begin cmp_a = heap_rdata.prio; cmp_b = cur.prio;        end
      S_UP_CMP:  begin cmp_a = cur.prio;        cmp_b = heap_rdata.prio; end
      S_DN_SCAN: begin cmp_a = heap_rdata.prio; cmp_b = best.prio;       end
      S_DN_DEC:  begin cmp_a = best.prio;       cmp_b = cur.prio;        end
      default:   begin cmp_a = cur.prio;        cmp_b = cur.prio;        end
    endcase
  end
  assign lt = cmp_a < cmp_b;

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = hole;
    heap_wdata = cur;
    heap_raddr = '0;
    map_we     = 1'b0;
    map_waddr  = cur.id;
    map_wdata  = hole;
    map_raddr  = task_id;
    unique case (state)
      S_EX_ROOT: heap_raddr = last[SLOT_W-1:0];
      S_DK_MAP:  heap_raddr = map_rdata;
      S_UP_CHK: begin
        if (hole == '0) begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end
      end
      S_UP_DIV:  heap_raddr = par_c;
      S_UP_CMP: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (lt) begin
          heap_wdata = heap_rdata;
          map_waddr  = heap_rdata.id;
        end
      end
      S_DN_START: begin
        if (child_base < {3'd0, occ}) begin
          heap_raddr = child_base[SLOT_W-1:0];
        end else begin
          heap_we = 1'b1;
          map_we  = 1'b1;
        end
      end
      S_DN_SCAN: heap_raddr = cidx_inc[SLOT_W-1:0];
      S_DN_DEC: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
        if (lt) begin
          heap_wdata = best;
          map_waddr  = best.id;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      arity     <= 4'd2;
      occ       <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        arity <= pwdata[ARITY_W-1:0];
      end
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_min    <= '0;
            res_status <= acc_status;
            cur        <= '{id: task_id, prio: priority_req};
            state      <= acc_state;
            if (acc_state == S_UP_CHK) begin
              hole             <= occ[SLOT_W-1:0];
              occ              <= occ + 9'd1;
              present[task_id] <= 1'b1;
            end
          end
        end
        S_EX_ROOT: begin
          res_min                  <= heap_rdata.id;
          present[heap_rdata.id]   <= 1'b0;
          occ                      <= last;
          state                    <= (last == '0) ? S_FIN : S_EX_LAST;
        end
        S_EX_LAST: begin
          cur   <= heap_rdata;
          hole  <= '0;
          state <= S_DN_START;
        end
        S_DK_MAP: begin
          hole <= map_rdata;
          if ({1'b0, map_rdata} >= occ) begin
            res_status <= ST_NOTFOUND;
            state      <= S_FIN;
          end else begin
            state <= S_DK_ENT;
          end
        end
        S_DK_ENT: begin
          if (lt) begin
            res_status <= ST_LARGER;
            state      <= S_FIN;
          end else begin
            state <= S_UP_CHK;
          end
        end
        S_UP_CHK: begin
          if (hole == '0) begin
            state <= S_FIN;
          end else begin
            q0    <= qprod[QPROD_W-1:RECIP_W];
            state <= S_UP_DIV;
          end
        end
        S_UP_DIV: begin
          par   <= par_c;
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (lt) begin
            hole  <= par;
            state <= S_UP_CHK;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_START: begin
          if (child_base < {3'd0, occ}) begin
            cidx     <= child_base;
            kcnt     <= '0;
            best_vld <= 1'b0;
            state    <= S_DN_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN_SCAN: begin
          if (!best_vld || lt) begin
            best      <= heap_rdata;
            best_slot <= cidx[SLOT_W-1:0];
            best_vld  <= 1'b1;
          end
          if (scan_more) begin
            cidx <= cidx_inc;
            kcnt <= kcnt + 4'd1;
          end else begin
            state <= S_DN_DEC;
          end
        end
        S_DN_DEC: begin
          if (lt) begin
            hole  <= best_slot;
            state <= S_DN_START;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            removed_id  <= res_min;
            entry_count <= occ;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IDMH_NEVER(a_occ_range, clk, rst, occ > 9'(CAPACITY))
  `IDMH_ASSERT(a_busy_after_accept, clk, rst, accept |=> in_stall)
  `IDMH_ASSERT(a_min_only_on_ok, clk, rst, (out_valid && status != ST_OK) |-> removed_id == '0)
  `IDMH_ASSERT(a_scan_in_heap, clk, rst, (state == S_DN_SCAN) |-> cidx < {3'd0, occ})
endmodule

[dv/indexed_dary_min_heap_tb.sv]
// Testbench for the indexed d-ary min-heap: directed, fill-to-full, random and backpressure tests.
// Holds its own heap model and checks every output transaction against it.
// Depends on idmh_pkg and the indexed_dary_min_heap RTL.
module indexed_dary_min_heap_tb;
  import idmh_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic [2:0]       status;
    logic [ID_W-1:0]  min_id;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           action = ACT_INSERT;
  logic [ID_W-1:0]      task_id = '0;
  logic [PRIO_BITS-1:0] priority_req = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic [ID_W-1:0]      removed_id;
  logic [CNT_W-1:0]     entry_count;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  indexed_dary_min_heap dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // heap model
  int unsigned heap_id[CAPACITY];
  int unsigned heap_prio[CAPACITY];
  int unsigned id_slot[ID_COUNT];
  bit          id_held[ID_COUNT];
  int unsigned held_count;
  int unsigned arity_reg;

  outcome_t expected_outcomes[$];
  int       mismatches;
  int       idle_pct;
  int       stall_pct;
  int       hold_left;
  int       hold_request;

  function automatic int unsigned branching();
    if (arity_reg < 2) return 2;
    if (arity_reg > MAX_ARITY) return MAX_ARITY;
    return arity_reg;
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    int unsigned t, p;
    t = heap_id[a];
    p = heap_prio[a];
    heap_id[a] = heap_id[b];
    heap_prio[a] = heap_prio[b];
    heap_id[b] = t;
    heap_prio[b] = p;
    id_slot[heap_id[a]] = a;
    id_slot[heap_id[b]] = b;
  endfunction

  function automatic void move_up(int unsigned i);
    int unsigned d, par;
    d = branching();
    while (i > 0) begin
      par = (i - 1) / d;
      if (!(heap_prio[i] < heap_prio[par])) break;
      swap_entries(i, par);
      i = par;
    end
  endfunction

  function automatic void move_down(int unsigned i);
    int unsigned d, best, c;
    d = branching();
    while (i < held_count) begin
      best = i;
      for (int unsigned k = 1; k <= d; k++) begin
        c = d * i + k;
        if (c < held_count && heap_prio[c] < heap_prio[best]) best = c;
      end
      if (best == i) break;
      swap_entries(i, best);
      i = best;
    end
  endfunction

  function automatic outcome_t heap_step(logic [1:0] act, logic [ID_W-1:0] id,
                                         logic [PRIO_BITS-1:0] prio);
    outcome_t r;
    int unsigned s;
    r.status = ST_OK;
    r.min_id = '0;
    case (act)
      ACT_INSERT: begin
        if (held_count >= CAPACITY) r.status = ST_FULL;
        else if (id_held[id]) r.status = ST_DUP;
        else begin
          s = held_count;
          heap_id[s] = 32'(id);
          heap_prio[s] = 32'(prio);
          id_slot[id] = s;
          id_held[id] = 1'b1;
          held_count = s + 1;
          move_up(s);
        end
      end
      ACT_EXTRACT: begin
        if (held_count == 0) r.status = ST_EMPTY;
        else begin
          r.min_id = ID_W'(heap_id[0]);
          id_held[heap_id[0]] = 1'b0;
          id_slot[heap_id[0]] = 0;
          held_count = held_count - 1;
          if (held_count > 0) begin
            heap_id[0] = heap_id[held_count];
            heap_prio[0] = heap_prio[held_count];
            id_slot[heap_id[0]] = 0;
            move_down(0);
          end
        end
      end
      ACT_DECREASE: begin
        if (!id_held[id]) r.status = ST_NOTFOUND;
        else begin
          s = id_slot[id];
          if (32'(prio) > heap_prio[s]) r.status = ST_LARGER;
          else begin
            heap_prio[s] = 32'(prio);
            move_up(s);
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(held_count);
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, logic [ID_W-1:0] id, logic [PRIO_BITS-1:0] prio);
    int gap;
    outcome_t o;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    task_id <= id;
    priority_req <= prio;
    do @(posedge clk); while (in_stall);
    o = heap_step(act, id, prio);
    expected_outcomes.insert(expected_outcomes.size(), o);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_outcomes.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_arity(int unsigned v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_ARITY, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    arity_reg = v & 4'hF;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[3:0] !== arity_reg[3:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("arity readback: expected %0d got %0d", arity_reg, prdata[3:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left <= hold_request;
      hold_request = 0;
    end else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk)
    out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: status %0d", status);
      end else begin
        e = expected_outcomes.pop_front();
        if (status !== e.status || removed_id !== e.min_id || entry_count !== e.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     e.status, e.min_id, e.count, status, removed_id, entry_count);
        end
      end
    end
  end

  task automatic test_directed();
    write_arity(2);
    send_item(ACT_EXTRACT, 8'd0, 16'd0);
    send_item(ACT_INSERT, 8'd255, 16'hFFFF);
    send_item(ACT_INSERT, 8'd255, 16'd1);
    send_item(ACT_EXTRACT, 8'd0, 16'd0);
    send_item(ACT_INSERT, 8'd0, 16'd0);
    send_item(ACT_INSERT, 8'd17, 16'd500);
    send_item(ACT_INSERT, 8'd170, 16'd500);
    send_item(ACT_INSERT, 8'd85, 16'hFFFF);
    send_item(ACT_DECREASE, 8'd99, 16'd1);
    send_item(ACT_DECREASE, 8'd17, 16'd600);
    send_item(ACT_DECREASE, 8'd17, 16'd500);
    send_item(ACT_DECREASE, 8'd85, 16'd0);
    send_item(ACT_SPARE, 8'hAA, 16'h5555);
    send_item(ACT_EXTRACT, 8'd0, 16'd0);
    send_item(ACT_EXTRACT, 8'd0, 16'd0);
    send_item(ACT_EXTRACT, 8'd0, 16'd0);
    send_item(ACT_EXTRACT, 8'd0, 16'd0);
    send_item(ACT_EXTRACT, 8'd0, 16'd0);
    send_item(ACT_DECREASE, 8'd0, 16'd0);
    drain();
  endtask

  task automatic test_fill_to_full();
    write_arity(15);
    for (int i = 0; i < CAPACITY; i++)
      send_item(ACT_INSERT, ID_W'(i * 37 + 11), PRIO_BITS'($urandom_range(0, 63)));
    send_item(ACT_INSERT, 8'd3, 16'd9);
    send_item(ACT_INSERT, 8'd250, 16'd0);
    send_item(ACT_DECREASE, 8'd11, 16'd0);
    for (int i = 0; i < CAPACITY + 1; i++) send_item(ACT_EXTRACT, 8'd0, 16'd0);
    drain();
  endtask

  task automatic random_item();
    int r;
    logic [ID_W-1:0] id;
    logic [PRIO_BITS-1:0] prio;
    int unsigned s;
    r = $urandom_range(99);
    id = ID_W'($urandom);
    prio = ($urandom_range(1)) ? PRIO_BITS'($urandom) : PRIO_BITS'($urandom_range(0, 31));
    if (r < 45) begin
      for (int k = 0; k < 8 && id_held[id] && $urandom_range(9) > 0; k++) id = ID_W'($urandom);
      send_item(ACT_INSERT, id, prio);
    end else if (r < 78) send_item(ACT_EXTRACT, id, prio);
    else if (r < 95 && held_count > 0) begin
      s = $urandom_range(held_count - 1);
      if ($urandom_range(9) == 0) prio = PRIO_BITS'(heap_prio[s] + $urandom_range(0, 3));
      else prio = PRIO_BITS'(heap_prio[s]
                             - $urandom_range(0, heap_prio[s] < 200 ? heap_prio[s] : 200));
      send_item(ACT_DECREASE, ID_W'(heap_id[s]), prio);
    end else if (r < 98) send_item(ACT_DECREASE, id, prio);
    else send_item(ACT_SPARE, id, prio);
  endtask

  task automatic test_random(int unsigned ar, int idle, int stall, int n);
    write_arity(ar);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) random_item();
    drain();
  endtask

  task automatic test_backpressure();
    write_arity(4);
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 500;
    repeat (30) random_item();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_outcomes.size() == 0);
    repeat (20) random_item();
    drain();
  endtask

  initial begin
    mismatches = 0;
    hold_left = 0;
    hold_request = 0;
    idle_pct = 0;
    stall_pct = 0;
    held_count = 0;
    arity_reg = 2;
    for (int i = 0; i < ID_COUNT; i++) begin
      id_held[i] = 1'b0;
      id_slot[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_to_full();
    test_random(2, 0, 0, 110);
    test_random(3, 75, 0, 110);
    test_random(5, 0, 75, 110);
    test_random(8, 33, 33, 110);
    test_random(0, 10, 10, 100);
    test_backpressure();
    test_random(1, 20, 20, 40);
    if (mismatches == 0 && expected_outcomes.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
